// ===== sv/assert_macros.svh =====
// Assertion shorthands used by the checker in pwmc_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/pwmc_pkg.sv =====
package pwmc_pkg;

  // Sequencer states of the controller.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RANGE,
    ST_DIV,
    ST_DONE
  } state_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_REF_HIGH = 3'd2,
    REG_REF_LOW  = 3'd3,
    REG_WAVE_LEN = 3'd4
  } reg_index_t;

  localparam int GAIN_W   = 24;
  localparam int ADC_W    = 10;
  localparam int ERR_W    = 11;
  localparam int WL_W     = 11;
  localparam int PHASE_W  = 10;
  localparam int PCT_W    = 7;
  localparam int DUTY_W   = 12;
  localparam int PROD_H_W = 27;
  localparam int PROD_W   = PROD_H_W + GAIN_W;
  localparam int NUM_W    = 35;
  localparam int CNT_W    = 5;

  localparam logic [CNT_W-1:0] MUL_LAST = 5'd23;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd6;

  localparam logic [WL_W-1:0] WL_MIN = 11'd2;
  localparam logic [WL_W-1:0] WL_MAX = 11'd1024;

  // Divisor 3999 * 65536 and its value shifted up by six bits.
  localparam logic [NUM_W-1:0] DEN_TOP = 35'd16773021696;

  // Limits of the PI sum outside which the percentage saturates.
  localparam logic signed [PROD_W-1:0] S_LO = -51'sd128418448;
  localparam logic signed [PROD_W-1:0] S_HI = 51'sd131039232;

  // Fifty times the divisor, added before the division.
  localparam logic [NUM_W:0] HALF_BIAS = 36'd13103923200;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic [GAIN_W-1:0]  KP_RESET       = 24'd0;
  localparam logic [GAIN_W-1:0]  KI_RESET       = 24'd0;
  localparam logic [ADC_W-1:0]   REF_HIGH_RESET = 10'd800;
  localparam logic [ADC_W-1:0]   REF_LOW_RESET  = 10'd200;
  localparam logic [WL_W-1:0]    WAVE_LEN_RESET = 11'd1000;

endpackage

// ===== sv/pi_pwm_duty_controller_top.sv =====
// PI light-level controller with a clamped PWM duty output.
// Input channel (s_*): one request per control tick carries a 10-bit converter
// sample. The block takes a request only while it is idle; s_tready is high
// in that state and low while a tick is being worked on.
// Output channel (m_*): one result request per tick with the duty, the
// clamped percentage, the reference used and the error.
// The reference, error and integral are captured at the accepting edge. The
// tick then passes in order through the one-bit-per-cycle shift-add
// multiplier that forms kp*err + ki*integral, a range and scaling step and
// restoring division for the percentage; the result is then loaded into the
// output register.
// A new request is taken only after the previous tick has been loaded into
// the output register, so the serial multiplier and divider set the rate as
// long as the receiver keeps up.
// The output register frees the input side: a new tick is accepted while the
// previous result still waits. If the receiver stalls, the finished tick
// waits in its last state until the output register empties.
// Configuration is a plain write port; writing kp or ki clears the integral.
// Reset (synchronous, rst high) restores the register defaults, clears the
// integral and the reference phase, and drops m_tvalid.
module pi_pwm_duty_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [11:0] duty, [18:12] percent,
                                 // [28:19] reference, [39:29] error_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  pwmc_pkg::state_t state, state_next;

  // Configuration registers.
  logic [pwmc_pkg::GAIN_W-1:0] kp, ki;
  logic [pwmc_pkg::ADC_W-1:0]  ref_high, ref_low;
  logic [pwmc_pkg::WL_W-1:0]   wave_length;

  // Controller state.
  logic [pwmc_pkg::GAIN_W-1:0]  integral;
  logic [pwmc_pkg::PHASE_W-1:0] phase;

  // Per-tick working registers.
  logic [pwmc_pkg::ADC_W-1:0]    ref_r;
  logic [pwmc_pkg::ERR_W-1:0]    err_r;
  logic [pwmc_pkg::GAIN_W-1:0]   eb, ab;
  logic [pwmc_pkg::PROD_H_W-1:0] prod_h;
  logic [pwmc_pkg::GAIN_W-1:0]   prod_l;
  logic [pwmc_pkg::CNT_W-1:0]    cnt;
  logic                          lo, hi;
  logic [pwmc_pkg::NUM_W-1:0]    rem, dvs;
  logic [pwmc_pkg::PCT_W-1:0]    quo;

  logic accept, load_out;

  // Wave-length clamp, reference selection, error, saturating integral and phase step.
  logic [pwmc_pkg::WL_W-1:0]    wl_eff;
  logic [pwmc_pkg::PHASE_W-1:0] half;
  logic [pwmc_pkg::ADC_W-1:0]   ref_sel;
  logic [pwmc_pkg::ERR_W-1:0]   err;
  logic [pwmc_pkg::GAIN_W:0]    acc_wide;
  logic [pwmc_pkg::GAIN_W-1:0]  acc_sat;
  logic [pwmc_pkg::WL_W-1:0]    phase_inc;
  logic [pwmc_pkg::PHASE_W-1:0] phase_next;

  always_comb begin
    if (wave_length < pwmc_pkg::WL_MIN) begin
      wl_eff = pwmc_pkg::WL_MIN;
    end else if (wave_length > pwmc_pkg::WL_MAX) begin
      wl_eff = pwmc_pkg::WL_MAX;
    end else begin
      wl_eff = wave_length;
    end
    half = wl_eff[pwmc_pkg::WL_W-1:1];
    ref_sel = (phase < half) ? ref_high : ref_low;
    err = {1'b0, ref_sel} - {1'b0, s_tdata[pwmc_pkg::ADC_W-1:0]};
    acc_wide = {integral[pwmc_pkg::GAIN_W-1], integral}
             + {{(pwmc_pkg::GAIN_W + 1 - pwmc_pkg::ERR_W){err[pwmc_pkg::ERR_W-1]}}, err};
    // The sum overflows when its two top bits differ; the top bit gives the side.
    if (acc_wide[pwmc_pkg::GAIN_W] != acc_wide[pwmc_pkg::GAIN_W-1]) begin
      acc_sat = acc_wide[pwmc_pkg::GAIN_W] ? {1'b1, {(pwmc_pkg::GAIN_W-1){1'b0}}}
                                           : {1'b0, {(pwmc_pkg::GAIN_W-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[pwmc_pkg::GAIN_W-1:0];
    end
    phase_inc = {1'b0, phase} + 11'd1;
    phase_next = (phase_inc >= wl_eff) ? '0 : phase_inc[pwmc_pkg::PHASE_W-1:0];
  end

  // One step of the shared shift-add multiplier: both products advance by
  // one multiplier bit per cycle. The last step carries the sign weight.
  logic [pwmc_pkg::PROD_H_W-1:0] kp_x, ki_x, term, mul_sum;

  always_comb begin
    kp_x = eb[0] ? {{(pwmc_pkg::PROD_H_W - pwmc_pkg::GAIN_W){kp[pwmc_pkg::GAIN_W-1]}}, kp}
                 : '0;
    ki_x = ab[0] ? {{(pwmc_pkg::PROD_H_W - pwmc_pkg::GAIN_W){ki[pwmc_pkg::GAIN_W-1]}}, ki}
                 : '0;
    term = kp_x + ki_x;
    mul_sum = (cnt == pwmc_pkg::MUL_LAST) ? (prod_h - term) : (prod_h + term);
  end

  // Range test and scaling of the finished PI sum, and the divider's compare.
  logic signed [pwmc_pkg::PROD_W-1:0] prod;
  logic [pwmc_pkg::NUM_W:0]           num_full;
  logic                               div_ge;

  always_comb begin
    prod = $signed({prod_h, prod_l});
    num_full = ({{7{prod[28]}}, prod[28:0]} * 36'd100) + pwmc_pkg::HALF_BIAS;
    div_ge = (rem >= dvs);
  end

  // Final percentage and duty: floor(p*3999/100) is 40p-1 for p above zero.
  logic [pwmc_pkg::PCT_W-1:0]  pct;
  logic [pwmc_pkg::DUTY_W-1:0] duty;

  always_comb begin
    if (lo) begin
      pct = '0;
    end else if (hi) begin
      pct = pwmc_pkg::PCT_MAX;
    end else begin
      pct = quo;
    end
    if (pct == '0) begin
      duty = '0;
    end else begin
      duty = ({5'b0, pct} * 12'd40) - 12'd1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    load_out = 1'b0;
    case (state)
      pwmc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = pwmc_pkg::ST_MUL;
        end
      end
      pwmc_pkg::ST_MUL: begin
        if (cnt == pwmc_pkg::MUL_LAST) begin
          state_next = pwmc_pkg::ST_RANGE;
        end
      end
      pwmc_pkg::ST_RANGE: begin
        state_next = pwmc_pkg::ST_DIV;
      end
      pwmc_pkg::ST_DIV: begin
        if (cnt == pwmc_pkg::DIV_LAST) begin
          state_next = pwmc_pkg::ST_DONE;
        end
      end
      pwmc_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out = 1'b1;
          state_next = pwmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pwmc_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // Configuration registers, integral and reference phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp          <= pwmc_pkg::KP_RESET;
      ki          <= pwmc_pkg::KI_RESET;
      ref_high    <= pwmc_pkg::REF_HIGH_RESET;
      ref_low     <= pwmc_pkg::REF_LOW_RESET;
      wave_length <= pwmc_pkg::WAVE_LEN_RESET;
      integral    <= '0;
      phase       <= '0;
    end else begin
      if (accept) begin
        integral <= acc_sat;
        phase    <= phase_next;
      end
      if (cfg_we) begin
        case (pwmc_pkg::reg_index_t'(cfg_index))
          pwmc_pkg::REG_KP: begin
            kp       <= cfg_data;
            integral <= '0;
          end
          pwmc_pkg::REG_KI: begin
            ki       <= cfg_data;
            integral <= '0;
          end
          pwmc_pkg::REG_REF_HIGH: begin
            ref_high <= cfg_data[pwmc_pkg::ADC_W-1:0];
          end
          pwmc_pkg::REG_REF_LOW: begin
            ref_low <= cfg_data[pwmc_pkg::ADC_W-1:0];
          end
          pwmc_pkg::REG_WAVE_LEN: begin
            wave_length <= cfg_data[pwmc_pkg::WL_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath: multiplier, range test and serial divider.
  always_ff @(posedge clk) begin
    case (state)
      pwmc_pkg::ST_IDLE: begin
        if (accept) begin
          ref_r  <= ref_sel;
          err_r  <= err;
          eb     <= {{(pwmc_pkg::GAIN_W - pwmc_pkg::ERR_W){err[pwmc_pkg::ERR_W-1]}}, err};
          ab     <= acc_sat;
          prod_h <= '0;
          prod_l <= '0;
          cnt    <= '0;
        end
      end
      pwmc_pkg::ST_MUL: begin
        prod_h <= {mul_sum[pwmc_pkg::PROD_H_W-1], mul_sum[pwmc_pkg::PROD_H_W-1:1]};
        prod_l <= {mul_sum[0], prod_l[pwmc_pkg::GAIN_W-1:1]};
        eb     <= {1'b0, eb[pwmc_pkg::GAIN_W-1:1]};
        ab     <= {1'b0, ab[pwmc_pkg::GAIN_W-1:1]};
        cnt    <= cnt + 5'd1;
      end
      pwmc_pkg::ST_RANGE: begin
        lo  <= (prod <= pwmc_pkg::S_LO);
        hi  <= (prod >= pwmc_pkg::S_HI);
        rem <= num_full[pwmc_pkg::NUM_W-1:0];
        dvs <= pwmc_pkg::DEN_TOP;
        quo <= '0;
        cnt <= '0;
      end
      pwmc_pkg::ST_DIV: begin
        if (div_ge) begin
          rem <= rem - dvs;
        end
        quo <= {quo[pwmc_pkg::PCT_W-2:0], div_ge};
        dvs <= {1'b0, dvs[pwmc_pkg::NUM_W-1:1]};
        cnt <= cnt + 5'd1;
      end
      pwmc_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {err_r, ref_r, pct, duty};
    end
  end

endmodule

// ===== sv/pwmc_check.sv =====
`include "assert_macros.svh"

module pwmc_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A stalled result stays offered.
  `CHK_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // Once a tick is taken the block is busy on the following cycle.
  `CHK_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // The percentage never leaves its clamp range.
  `CHK_IMPL(a_pct_range, clk, rst, m_tvalid, m_tdata[18:12] <= 7'd100)

  // The duty follows the percentage as 40p-1, or zero at zero percent.
  `CHK_IMPL(a_duty_match, clk, rst, m_tvalid,
    ((m_tdata[18:12] == 7'd0) && (m_tdata[11:0] == 12'd0)) ||
    ((m_tdata[18:12] != 7'd0) &&
     (m_tdata[11:0] == (({5'b0, m_tdata[18:12]} * 12'd40) - 12'd1))))

endmodule

bind pi_pwm_duty_controller_top pwmc_check u_pwmc_check (.*);

// ===== sim/tb_pi_pwm_duty_controller_top.sv =====
module tb_pi_pwm_duty_controller_top;
  import pwmc_pkg::*;

  // Index above the register file; a write there must change nothing.
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam longint PWM_TOP   = 3999;
  localparam longint PCT_FULL  = 100;
  localparam longint PCT_DIV   = PWM_TOP * 65536;
  localparam longint INTEG_MAX = 8388607;
  localparam longint INTEG_MIN = -8388608;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS   = 105;
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_AT       = 300;
  localparam int TAIL_CYCLES   = 60;
  localparam int CYCLE_LIMIT   = 3000000;

  // Result fields ordered MSB first so the struct matches the m_tdata layout.
  typedef struct packed {
    logic [10:0] err;
    logic [9:0]  lvl;
    logic [6:0]  pct;
    logic [11:0] duty;
  } tick_result_t;

  // One row of the directed table: an optional register write before the tick,
  // the sample, and a hand-typed result where one is obvious.
  typedef struct {
    bit           do_cfg;
    logic [2:0]   idx;
    logic [23:0]  data;
    logic [9:0]   sample;
    bit           typed;
    tick_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  pi_pwm_duty_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the controller's registers and state.
  logic signed [23:0] kp_gain;
  logic signed [23:0] ki_gain;
  logic [9:0]         ref_hi;
  logic [9:0]         ref_lo;
  logic [10:0]        wave_len;
  longint             integ;
  int                 phase;

  // Results predicted for accepted requests, oldest first.
  tick_result_t pending_results[$];
  dir_row_t     dir_tab[$];

  int  ticks_sent;
  int  results_seen;
  int  mismatches;
  int  cycles;
  bit  steady;
  bit  held;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard: a correct run finishes far below this count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still awaited", $time, cycles,
               pending_results.size());
      $display("tb_pi_pwm_duty_controller_top NOT OK");
      $finish;
    end
  end

  // The block clamps the wave length to 2..1024 before it uses it.
  function automatic int eff_wave_len();
    int wl;
    wl = wave_len;
    if (wl < int'(WL_MIN)) wl = WL_MIN;
    if (wl > int'(WL_MAX)) wl = WL_MAX;
    return wl;
  endfunction

  // High level for the first half of the square wave, low level for the rest.
  function automatic logic [9:0] level_now();
    return (phase < eff_wave_len() / 2) ? ref_hi : ref_lo;
  endfunction

  function automatic void cfg_apply(input logic [2:0] idx, input logic [23:0] data);
    case (idx)
      REG_KP: begin
        kp_gain = data;
        integ = 0;
      end
      REG_KI: begin
        ki_gain = data;
        integ = 0;
      end
      REG_REF_HIGH: ref_hi = data[9:0];
      REG_REF_LOW:  ref_lo = data[9:0];
      REG_WAVE_LEN: wave_len = data[10:0];
      default: ;
    endcase
  endfunction

  // One control tick: error, saturating integral, PI sum, percent and duty,
  // then the phase step.
  function automatic tick_result_t control_tick(input logic [9:0] sample);
    longint err;
    longint acc;
    longint pi_sum;
    longint pct;
    tick_result_t r;
    r.lvl = level_now();
    err = longint'(r.lvl) - longint'(sample);
    acc = integ + err;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ = acc;
    pi_sum = longint'(kp_gain) * err + longint'(ki_gain) * integ;
    // Signed division truncates toward zero, as the block does.
    pct = (pi_sum * PCT_FULL + 50 * PCT_DIV) / PCT_DIV;
    if (pct > PCT_FULL) pct = PCT_FULL;
    if (pct < 0) pct = 0;
    r.pct = pct[6:0];
    r.duty = 12'((pct * PWM_TOP) / PCT_FULL);
    r.err = err[10:0];
    if (phase + 1 >= eff_wave_len()) phase = 0;
    else phase = phase + 1;
    return r;
  endfunction

  function automatic tick_result_t res(input int duty, input int pct, input int lvl,
                                       input int err);
    tick_result_t r;
    r.duty = 12'(duty);
    r.pct = 7'(pct);
    r.lvl = 10'(lvl);
    r.err = 11'(err);
    return r;
  endfunction

  function automatic logic [23:0] pick_gain();
    logic [23:0] g;
    case ($urandom_range(9))
      0: g = 24'h7FFFFF;
      1: g = 24'h800000;
      2, 3, 4, 5: g = 24'(int'($urandom_range(80000)) - 40000);
      6, 7, 8: g = 24'(int'($urandom_range(800)) - 400);
      default: g = 24'($urandom);
    endcase
    return g;
  endfunction

  function automatic logic [23:0] pick_level();
    case ($urandom_range(3))
      0: return 24'd0;
      1: return 24'd1023;
      default: return 24'($urandom_range(1023));
    endcase
  endfunction

  // Lengths below 2 and above 1024 exercise the clamping; short ones wrap often.
  function automatic logic [23:0] pick_wave_len();
    case ($urandom_range(7))
      0: return 24'($urandom_range(1));
      1: return 24'd2;
      2: return 24'd3;
      3: return 24'd1024;
      4: return 24'($urandom_range(2047, 1025));
      default: return 24'($urandom_range(40, 4));
    endcase
  endfunction

  // All sender-side tasks are entered and left at a falling edge.
  task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    cfg_apply(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one request; the prediction is made at the edge that accepts it.
  task automatic send_tick(input logic [9:0] sample, input bit typed,
                           input tick_result_t want);
    tick_result_t predicted;
    while (!steady && $urandom_range(99) < 36) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {6'd0, sample};
    do @(posedge clk); while (!s_tready);
    predicted = control_tick(sample);
    pending_results.push_back(typed ? want : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Registers may only change while the block is idle. Every tick yields a
  // result, so an empty queue means the datapath has nothing in flight.
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic new_settings(input bit all);
    if (all || $urandom_range(1)) cfg_write(REG_KP, pick_gain());
    if (all || $urandom_range(1)) cfg_write(REG_KI, pick_gain());
    if (all || $urandom_range(1)) cfg_write(REG_REF_HIGH, pick_level());
    if (all || $urandom_range(1)) cfg_write(REG_REF_LOW, pick_level());
    if (all || $urandom_range(1)) cfg_write(REG_WAVE_LEN, pick_wave_len());
    if ($urandom_range(3) == 0) cfg_write(REG_NONE, 24'($urandom));
  endtask

  task automatic report(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Result checker: every accepted result request is compared with the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = tick_result_t'(m_tdata);
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result, duty", 0, got.duty);
      end else begin
        want = pending_results.pop_front();
        if (got.duty !== want.duty) report("duty", want.duty, got.duty);
        if (got.pct !== want.pct) report("percent", want.pct, got.pct);
        if (got.lvl !== want.lvl) report("reference", want.lvl, got.lvl);
        if (got.err !== want.err)
          report("error_value", $signed(want.err), $signed(got.err));
      end
    end
  end

  // Result receiver. It stalls at random, never during the steady stretch, and
  // once holds off for a long while so the block fills up and refuses requests.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready = steady || ($urandom_range(99) >= 36);
    end
  end

  initial begin
    // With both gains at zero the percentage sits at 50 and the duty at 1999.
    // Hand-typed rows cover the rails of the gains, the error extremes and the
    // clamping of short and long wave lengths; the rest go to the predictor.
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd0, 1, res(1999, 50, 800, 800)});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd1023, 1, res(1999, 50, 800, -223)});
    dir_tab.push_back('{1, REG_KP, 24'h7FFFFF, 10'd0, 1, res(3999, 100, 800, 800)});
    dir_tab.push_back('{1, REG_KP, 24'h800000, 10'd0, 1, res(0, 0, 800, 800)});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd1023, 1, res(3999, 100, 800, -223)});
    dir_tab.push_back('{1, REG_KP, 24'd0, 10'd512, 1, res(1999, 50, 800, 288)});
    dir_tab.push_back('{1, REG_KI, 24'h7FFFFF, 10'd0, 1, res(3999, 100, 800, 800)});
    dir_tab.push_back('{1, REG_KI, 24'h800000, 10'd1023, 1, res(3999, 100, 800, -223)});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd0, 1, res(0, 0, 800, 800)});
    dir_tab.push_back('{1, REG_KI, 24'd0, 10'd800, 1, res(1999, 50, 800, 0)});
    dir_tab.push_back('{1, REG_REF_HIGH, 24'd1023, 10'd0, 1, res(1999, 50, 1023, 1023)});
    dir_tab.push_back('{1, REG_REF_LOW, 24'd0, 10'd1023, 1, res(1999, 50, 1023, 0)});
    // Phase is far past the shortened period here, so it wraps to zero.
    dir_tab.push_back('{1, REG_WAVE_LEN, 24'd0, 10'd1023, 1, res(1999, 50, 0, -1023)});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd0, 1, res(1999, 50, 1023, 1023)});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd0, 1, res(1999, 50, 0, 0)});
    dir_tab.push_back('{1, REG_WAVE_LEN, 24'd1, 10'd5, 1, res(1999, 50, 1023, 1018)});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd5, 1, res(1999, 50, 0, -5)});
    dir_tab.push_back('{1, REG_WAVE_LEN, 24'd2047, 10'd0, 1, res(1999, 50, 1023, 1023)});
    dir_tab.push_back('{1, REG_WAVE_LEN, 24'd3, 10'd0, 1, res(1999, 50, 0, 0)});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd0, 1, res(1999, 50, 0, 0)});
    dir_tab.push_back('{1, REG_NONE, 24'hFFFFFF, 10'd0, 1, res(1999, 50, 1023, 1023)});
    dir_tab.push_back('{1, REG_KP, 24'd16000, 10'd300, 0, '0});
    dir_tab.push_back('{1, REG_KI, 24'd300, 10'd100, 0, '0});
    dir_tab.push_back('{0, REG_KP, 24'd0, 10'd1023, 0, '0});
    dir_tab.push_back('{1, REG_REF_HIGH, 24'd700, 10'd650, 0, '0});

    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_KP;
    cfg_data = '0;
    steady = 1'b0;
    held = 1'b0;
    ticks_sent = 0;
    results_seen = 0;
    mismatches = 0;
    cycles = 0;
    kp_gain = KP_RESET;
    ki_gain = KI_RESET;
    ref_hi = REF_HIGH_RESET;
    ref_lo = REF_LOW_RESET;
    wave_len = WAVE_LEN_RESET;
    integ = 0;
    phase = 0;

    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].do_cfg) begin
        drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end
      send_tick(dir_tab[i].sample, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases, each under a fresh register setting. Some samples land
    // near the reference so the error stays small and the percentage moves
    // inside its range instead of sitting on a clamp.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      new_settings(ph == 0);
      steady = (ph == 4);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        int s;
        if ($urandom_range(3) == 0) begin
          s = int'(level_now()) + int'($urandom_range(32)) - 16;
          if (s < 0) s = 0;
          if (s > 1023) s = 1023;
        end else begin
          s = $urandom_range(1023);
        end
        send_tick(10'(s), 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Ran %0d control ticks: directed rows and %0d randomly configured phases",
             ticks_sent, RANDOM_PHASES);
    $display("with random stalls and one long receiver hold; %0d results checked, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_pi_pwm_duty_controller_top OK");
    end else begin
      $display("tb_pi_pwm_duty_controller_top NOT OK");
    end
    $finish;
  end

endmodule
